// File: sv/ntc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NTC converter package
// Shared state encoding, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int DIV_W  = 44;   // dividend and quotient width of the divider
   localparam int DIVR_W = 30;   // divisor width of the divider
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PULLUP  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_T0      = 4'd3;

   localparam logic [31:0]       LN2_Q32      = 32'd2977044472;
   localparam logic [12:0]       OK_MARGIN_MV = 13'd10;
   localparam logic signed [11:0] TEMP_MIN_DECI = -12'sd1000;
   localparam logic signed [11:0] TEMP_MAX_DECI = 12'sd2000;
   localparam logic [28:0]       TEMP_MIN_MAG = 29'd1000;
   localparam logic [28:0]       TEMP_MAX_MAG = 29'd2000;
   localparam logic [44:0]       KELVIN_OFS   = 45'd895057920;   // 27315 * 2^15
   localparam logic [DIV_W-1:0]  F_NUM        = 44'd10995116277760; // 10 * 2^40
   localparam logic [DIV_W-1:0]  T0_NUM       = 44'd3355443200;  // 200 * 2^24
   localparam logic [16:0]       KELVIN_C100  = 17'd27315;

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_NUM    = 18'h00002,
      S_DEN    = 18'h00004,
      S_CHK    = 18'h00008,
      S_NORM   = 18'h00010,
      S_SQR    = 18'h00020,
      S_LNHI   = 18'h00040,
      S_LNLO   = 18'h00080,
      S_T0     = 18'h00100,
      S_T0W    = 18'h00200,
      S_BETA   = 18'h00400,
      S_BETAW  = 18'h00800,
      S_SUM    = 18'h01000,
      S_FDIV   = 18'h02000,
      S_FDIVW  = 18'h04000,
      S_FIN    = 18'h08000,
      S_EMIT   = 18'h10000,
      S_SPARE  = 18'h20000
   } state_type;

endpackage
`default_nettype wire

// File: sv/ntc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NTC iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_div
   import ntc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   done,
   output logic [DIV_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

   logic [DIVR_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIVR_W:0]   trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVR_W'(trial - {1'b0, div_ff}) : trial[DIVR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: sv/ntc_beta_thermistor_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NTC beta thermistor converter
// Turns a pair of divider millivolt readings into a temperature in 0.1 C.
// ----------------------------------------------------------------------------
// Usage: a transaction on the req_ channel carries the divider reference and
// the thermistor voltage. Each accepted transaction yields exactly one
// transaction on the rsp_ channel with the temperature and status flags.
// The csr_ channel writes the pull-up, nominal resistance, beta and reference
// temperature registers; it is always ready and must only be used while the
// block is idle.
// Conversion steps: a faulted reading goes straight to the result state. A
// valid reading passes three setup states (S_NUM, S_DEN, S_CHK), two base-2
// logarithms (5 normalize steps and 24 squarings each, on the
// shared 31x31 multiplier), two multiplies for the ln(2) scale and
// three 44-step passes through the shared restoring divider (1/T0, division
// by beta and the final reciprocal). The divider passes take most of the time.
// One reading is converted at a time; req_stall is high while converting.
// Reset loads the register defaults and assumes the sensor is in fault.
// When the receiver stalls, the result register holds its transaction and a
// finished conversion waits in its last state until the register frees up.
// ----------------------------------------------------------------------------
module ntc_beta_thermistor_converter
   import ntc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [11:0]          req_ref_millivolts,
   input  wire logic [11:0]          req_sense_millivolts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [11:0]        rsp_temp_deci_c,
   output logic                      rsp_sensor_ok,
   output logic                      rsp_fault_raised,
   output logic                      rsp_clamped,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [19:0]          csr_data
);

   // Configuration registers.
   logic [19:0] pullup_ff, nominal_ff;
   logic [13:0] beta_ff;
   logic [6:0]  t0c_ff;

   state_type state_ff, state_in;
   logic        in_fault_ff, in_fault_in;

   // Working registers.
   logic [11:0] ref_ff, ref_in, sense_ff, sense_in;
   logic [31:0] num_ff, num_in, den_ff, den_in, x_ff, x_in;
   logic [4:0]  k_ff, k_in, step_ff, step_in;
   logic        second_ff, second_in;
   logic [30:0] m_ff, m_in;
   logic [23:0] frac_ff, frac_in;
   logic [28:0] lognum_ff, lognum_in, logden_ff, logden_in;
   logic [45:0] prod_ff, prod_in;
   logic [29:0] lnmag_ff, lnmag_in, q_ff, q_in, s_ff, s_in;
   logic [16:0] invt0_ff, invt0_in;
   logic [DIV_W-1:0] f_ff, f_in;

   // Pending result.
   logic signed [11:0] res_temp_ff, res_temp_in;
   logic        res_ok_ff, res_ok_in, res_raised_ff, res_raised_in;
   logic        res_clamp_ff, res_clamp_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [11:0] rsp_temp_ff;
   logic        rsp_ok_ff, rsp_raised_ff, rsp_clamp_ff;
   logic        rsp_load;

   // Shared multiplier.
   logic [30:0] mul_a, mul_b;
   logic [61:0] mul_p;

   // Divider hookup.
   logic              div_start;
   logic              div_done;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [DIV_W-1:0]  div_quot;

   // Helpers.
   logic        req_take, ok_reading;
   logic [4:0]  sh;
   logic [31:0] hi_mask, x_next;
   logic [4:0]  k_next;
   logic        hi_zero;
   logic [31:0] sq;
   logic [28:0] log_val;
   logic        d2_neg;
   logic [28:0] d2_mag;
   logic [61:0] ln_acc;
   logic [16:0] t0_d;
   logic [13:0] beta_eff;
   logic [31:0] s_sum;
   logic [44:0] dk, dk_abs;
   logic [28:0] t_abs;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ok_reading = ({1'b0, req_sense_millivolts} + OK_MARGIN_MV)
                       < {1'b0, req_ref_millivolts};
   assign csr_ready = 1'b1;

   assign rsp_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign mul_p = 62'(mul_a) * 62'(mul_b);

   ntc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      // Normalize step: shift by 16, 8, 4, 2, 1 until the MSB sits at bit 31.
      sh      = 5'd16 >> step_ff[2:0];
      hi_mask = ~(32'hFFFF_FFFF >> sh);
      hi_zero = (x_ff & hi_mask) == 32'd0;
      x_next  = hi_zero ? (x_ff << sh) : x_ff;
      k_next  = hi_zero ? (k_ff - sh) : k_ff;

      sq      = mul_p[61:30];
      log_val = {k_ff, frac_ff[22:0], sq[31]};

      d2_neg  = logden_ff > lognum_ff;
      d2_mag  = d2_neg ? (logden_ff - lognum_ff) : (lognum_ff - logden_ff);
      ln_acc  = {prod_ff, 16'd0} + mul_p + (62'd1 << 31);

      t0_d     = 17'(t0c_ff) * 17'd100 + KELVIN_C100;
      beta_eff = (beta_ff == 14'd0) ? 14'd1 : beta_ff;
      s_sum    = d2_neg ? ({15'd0, invt0_ff} - {2'd0, q_ff})
                        : ({15'd0, invt0_ff} + {2'd0, q_ff});

      dk     = {1'b0, f_ff} - KELVIN_OFS;
      dk_abs = dk[44] ? (45'd0 - dk) : dk;
      t_abs  = dk_abs[44:16];
   end

   always_comb begin
      state_in      = state_ff;
      in_fault_in   = in_fault_ff;
      ref_in        = ref_ff;
      sense_in      = sense_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      x_in          = x_ff;
      k_in          = k_ff;
      step_in       = step_ff;
      second_in     = second_ff;
      m_in          = m_ff;
      frac_in       = frac_ff;
      lognum_in     = lognum_ff;
      logden_in     = logden_ff;
      prod_in       = prod_ff;
      lnmag_in      = lnmag_ff;
      invt0_in      = invt0_ff;
      q_in          = q_ff;
      s_in          = s_ff;
      f_in          = f_ff;
      res_temp_in   = res_temp_ff;
      res_ok_in     = res_ok_ff;
      res_raised_in = res_raised_ff;
      res_clamp_in  = res_clamp_ff;
      mul_a         = m_ff;
      mul_b         = m_ff;
      div_start     = 1'b0;
      div_dividend  = T0_NUM + 44'(t0_d);
      div_divisor   = {12'd0, t0_d, 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ref_in   = req_ref_millivolts;
               sense_in = req_sense_millivolts;
               if (ok_reading) begin
                  in_fault_in   = 1'b0;
                  res_ok_in     = 1'b1;
                  res_raised_in = 1'b0;
                  state_in      = S_NUM;
               end else begin
                  res_temp_in   = 12'sd0;
                  res_ok_in     = 1'b0;
                  res_raised_in = !in_fault_ff;
                  res_clamp_in  = 1'b0;
                  in_fault_in   = 1'b1;
                  state_in      = S_EMIT;
               end
            end
         end
         S_NUM: begin
            mul_a    = {19'd0, sense_ff};
            mul_b    = {11'd0, pullup_ff};
            num_in   = mul_p[31:0];
            state_in = S_DEN;
         end
         S_DEN: begin
            mul_a    = {19'd0, ref_ff - sense_ff};
            mul_b    = {11'd0, nominal_ff};
            den_in   = mul_p[31:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (num_ff == 32'd0 || den_ff == 32'd0) begin
               res_temp_in  = TEMP_MIN_DECI;
               res_clamp_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               x_in      = num_ff;
               k_in      = 5'd31;
               step_in   = 5'd0;
               second_in = 1'b0;
               state_in  = S_NORM;
            end
         end
         S_NORM: begin
            x_in    = x_next;
            k_in    = k_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd4) begin
               m_in     = x_next[31:1];
               frac_in  = 24'd0;
               step_in  = 5'd0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            // Square the mantissa; a result of two or more yields a one bit.
            m_in    = sq[31] ? sq[31:1] : sq[30:0];
            frac_in = {frac_ff[22:0], sq[31]};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd23) begin
               step_in = 5'd0;
               if (!second_ff) begin
                  lognum_in = log_val;
                  x_in      = den_ff;
                  k_in      = 5'd31;
                  second_in = 1'b1;
                  state_in  = S_NORM;
               end else begin
                  logden_in = log_val;
                  state_in  = S_LNHI;
               end
            end
         end
         S_LNHI: begin
            mul_a    = {2'd0, d2_mag};
            mul_b    = {15'd0, LN2_Q32[31:16]};
            prod_in  = mul_p[45:0];
            state_in = S_LNLO;
         end
         S_LNLO: begin
            mul_a    = {2'd0, d2_mag};
            mul_b    = {15'd0, LN2_Q32[15:0]};
            lnmag_in = ln_acc[61:32];
            state_in = S_T0;
         end
         S_T0: begin
            div_start = 1'b1;
            state_in  = S_T0W;
         end
         S_T0W: begin
            if (div_done) begin
               invt0_in = div_quot[16:0];
               state_in = S_BETA;
            end
         end
         S_BETA: begin
            div_start    = 1'b1;
            div_dividend = {14'd0, lnmag_ff};
            div_divisor  = {16'd0, beta_eff};
            state_in     = S_BETAW;
         end
         S_BETAW: begin
            if (div_done) begin
               q_in     = div_quot[29:0];
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (s_sum[31]) begin
               res_temp_in  = TEMP_MIN_DECI;
               res_clamp_in = 1'b1;
               state_in     = S_EMIT;
            end else if (s_sum == 32'd0) begin
               res_temp_in  = TEMP_MAX_DECI;
               res_clamp_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               s_in     = s_sum[29:0];
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            div_start    = 1'b1;
            div_dividend = F_NUM;
            div_divisor  = s_ff;
            state_in     = S_FDIVW;
         end
         S_FDIVW: begin
            if (div_done) begin
               f_in     = div_quot;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // Deci-kelvin minus the offset, truncated toward zero, then clamped.
            res_clamp_in = 1'b0;
            if (dk[44]) begin
               if (t_abs > TEMP_MIN_MAG) begin
                  res_temp_in  = TEMP_MIN_DECI;
                  res_clamp_in = 1'b1;
               end else begin
                  res_temp_in = $signed(12'd0 - t_abs[11:0]);
               end
            end else begin
               if (t_abs > TEMP_MAX_MAG) begin
                  res_temp_in  = TEMP_MAX_DECI;
                  res_clamp_in = 1'b1;
               end else begin
                  res_temp_in = $signed(t_abs[11:0]);
               end
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_fault_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         pullup_ff    <= 20'd10000;
         nominal_ff   <= 20'd10000;
         beta_ff      <= 14'd3950;
         t0c_ff       <= 7'd25;
      end else begin
         state_ff     <= state_in;
         in_fault_ff  <= in_fault_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PULLUP:  pullup_ff  <= csr_data;
               CSR_NOMINAL: nominal_ff <= csr_data;
               CSR_BETA:    beta_ff    <= csr_data[13:0];
               CSR_T0:      t0c_ff     <= csr_data[6:0];
               default: begin
               end
            endcase
         end
      end
      ref_ff        <= ref_in;
      sense_ff      <= sense_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      x_ff          <= x_in;
      k_ff          <= k_in;
      step_ff       <= step_in;
      second_ff     <= second_in;
      m_ff          <= m_in;
      frac_ff       <= frac_in;
      lognum_ff     <= lognum_in;
      logden_ff     <= logden_in;
      prod_ff       <= prod_in;
      lnmag_ff      <= lnmag_in;
      invt0_ff      <= invt0_in;
      q_ff          <= q_in;
      s_ff          <= s_in;
      f_ff          <= f_in;
      res_temp_ff   <= res_temp_in;
      res_ok_ff     <= res_ok_in;
      res_raised_ff <= res_raised_in;
      res_clamp_ff  <= res_clamp_in;
      if (rsp_load) begin
         rsp_temp_ff   <= res_temp_ff;
         rsp_ok_ff     <= res_ok_ff;
         rsp_raised_ff <= res_raised_ff;
         rsp_clamp_ff  <= res_clamp_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_deci_c  = rsp_temp_ff;
   assign rsp_sensor_ok    = rsp_ok_ff;
   assign rsp_fault_raised = rsp_raised_ff;
   assign rsp_clamped      = rsp_clamp_ff;

endmodule
`default_nettype wire

// File: sv/ntc_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NTC converter checker
// Port-level assertions on the converter, attached by bind.
// ----------------------------------------------------------------------------
module ntc_chk
   import ntc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic signed [11:0]   rsp_temp_deci_c,
   input wire logic                 rsp_sensor_ok,
   input wire logic                 rsp_fault_raised,
   input wire logic                 rsp_clamped
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A faulted reading reports zero temperature and no clamp.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sensor_ok |-> rsp_temp_deci_c == 12'sd0 && !rsp_clamped)
      else $error("faulted result carries a temperature");

   // The fault pulse only comes with a faulted reading.
   a_raise_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_raised |-> !rsp_sensor_ok)
      else $error("fault raised on a valid reading");

   // Valid readings stay within the output range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_ok |->
         rsp_temp_deci_c >= TEMP_MIN_DECI && rsp_temp_deci_c <= TEMP_MAX_DECI)
      else $error("temperature out of range");

   // After taking a transaction the block is busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

endmodule

bind ntc_beta_thermistor_converter ntc_chk u_ntc_chk (.*);
`default_nettype wire

// File: tb/ntc_beta_thermistor_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTC beta thermistor converter testbench
// Drives millivolt reading pairs under several register settings with random
// idling and a long receiver hold-off. A bit-accurate fixed-point predictor
// computes each temperature and status, and results are checked in order.
// ----------------------------------------------------------------------------
module ntc_beta_thermistor_converter_test;
   import ntc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 400;   // idle cycles waited after the queues empty
   localparam int HOLD_CYCLES = 1500;
   localparam longint unsigned LN2_FRAC = 64'd2977044472;

   typedef struct packed {
      logic [11:0] ref_mv;
      logic [11:0] sense_mv;
   } reading_type;

   typedef struct packed {
      logic signed [11:0] temp;
      logic               ok;
      logic               raised;
      logic               clamped;
   } temperature_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [11:0] req_ref_millivolts = '0;
   logic [11:0] req_sense_millivolts = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [11:0] rsp_temp_deci_c;
   logic rsp_sensor_ok;
   logic rsp_fault_raised;
   logic rsp_clamped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [19:0] csr_data = '0;

   ntc_beta_thermistor_converter i_dut (.*);

   // Stimulus and expectation stores.
   reading_type     pending_readings[$];
   temperature_type expected_temps[$];

   // Predictor copy of the registers and the fault state.
   logic [19:0] pullup_ohms, nominal_ohms;
   logic [13:0] beta_kelvin;
   logic [6:0]  nominal_temp_c;
   logic        in_fault;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   logic running = 1'b0;
   logic req_fire = 1'b0;
   int mismatches = 0;
   int cycles = 0;
   int n_ok = 0, n_fault = 0, n_raised = 0, n_clamped = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Base-2 logarithm in Q.24: the msb index plus 24 fraction bits, found by
   // repeatedly squaring the Q1.30 mantissa.
   function automatic longint log2_q24(longint unsigned x);
      int msb;
      longint unsigned m;
      longint frac;
      msb = 63;
      frac = 0;
      while (msb > 0 && x[msb] == 1'b0)
         msb--;
      m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | (longint'(1) << (23 - i));
         end
      end
      return longint'(msb) * (longint'(1) << 24) + frac;
   endfunction

   // Temperature in deci-degrees for a good reading; sets saturated when the
   // result was forced to one end of the output range.
   function automatic logic signed [11:0] beta_temperature(logic [11:0] ref_mv,
         logic [11:0] sense_mv, output logic saturated);
      longint unsigned num, den, mag, t0_den, f, beta;
      longint d2, lnq, s, inv_t0, dk;
      saturated = 1'b1;
      num = longint'(sense_mv) * longint'(pullup_ohms);
      den = longint'(ref_mv - sense_mv) * longint'(nominal_ohms);
      if (num == 0 || den == 0)
         return TEMP_MIN_DECI;
      d2 = log2_q24(num) - log2_q24(den);
      mag = (d2 < 0) ? longint'(-d2) : longint'(d2);
      mag = (mag * LN2_FRAC + (64'd1 << 31)) >> 32;
      lnq = (d2 < 0) ? -longint'(mag) : longint'(mag);
      beta = (beta_kelvin == 0) ? 64'd1 : longint'(beta_kelvin);
      t0_den = 64'd100 * nominal_temp_c + 64'd27315;
      inv_t0 = longint'(((64'd100 << 24) * 2 + t0_den) / (2 * t0_den));
      s = lnq / longint'(beta) + inv_t0;
      if (s < 0)
         return TEMP_MIN_DECI;
      if (s == 0)
         return TEMP_MAX_DECI;
      f = (64'd10 << 40) / longint'(s);
      dk = longint'(f) - longint'(27315) * (longint'(1) << 15);
      // Truncate toward zero rather than floor.
      dk = (dk >= 0) ? (dk >>> 16) : -((-dk) >>> 16);
      if (dk < -1000)
         return TEMP_MIN_DECI;
      if (dk > 2000)
         return TEMP_MAX_DECI;
      saturated = 1'b0;
      return dk[11:0];
   endfunction

   // Sender: a new transaction is offered only once the previous one was taken.
   always @(negedge clock) begin
      if (running && (!req_valid || req_fire)) begin
         if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            reading_type r;
            r = pending_readings.pop_front();
            req_valid <= 1'b1;
            req_ref_millivolts <= r.ref_mv;
            req_sense_millivolts <= r.sense_mv;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested so
   // that the converter fills up and pushes back on its input.
   always @(negedge clock) begin
      if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predicts on each accepted reading, checks each accepted result
   // and mirrors every register write into the predictor.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULLUP:  pullup_ohms <= csr_data;
               CSR_NOMINAL: nominal_ohms <= csr_data;
               CSR_BETA:    beta_kelvin <= csr_data[13:0];
               CSR_T0:      nominal_temp_c <= csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            temperature_type e;
            logic sat;
            // Good when the thermistor voltage sits more than 10 mV below reference.
            if (13'(req_sense_millivolts) + 13'd10 < 13'(req_ref_millivolts)) begin
               e.temp = beta_temperature(req_ref_millivolts, req_sense_millivolts, sat);
               e.ok = 1'b1;
               e.raised = 1'b0;
               e.clamped = sat;
               in_fault <= 1'b0;
            end else begin
               e = '0;
               e.raised = !in_fault;
               in_fault <= 1'b1;
            end
            expected_temps.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_temps.size() == 0) begin
               $error("unexpected result transaction");
               mismatches++;
            end else begin
               temperature_type e;
               e = expected_temps.pop_front();
               if (rsp_temp_deci_c !== e.temp) begin
                  $error("temp_deci_c expected %0d actual %0d", e.temp, rsp_temp_deci_c);
                  mismatches++;
               end
               if (rsp_sensor_ok !== e.ok) begin
                  $error("sensor_ok expected %0b actual %0b", e.ok, rsp_sensor_ok);
                  mismatches++;
               end
               if (rsp_fault_raised !== e.raised) begin
                  $error("fault_raised expected %0b actual %0b", e.raised, rsp_fault_raised);
                  mismatches++;
               end
               if (rsp_clamped !== e.clamped) begin
                  $error("clamped expected %0b actual %0b", e.clamped, rsp_clamped);
                  mismatches++;
               end
               n_ok += e.ok;
               n_fault += !e.ok;
               n_raised += e.raised;
               n_clamped += e.clamped;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [19:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_reading(int ref_mv, int sense_mv);
      reading_type r;
      r.ref_mv = 12'(ref_mv);
      r.sense_mv = 12'(sense_mv);
      pending_readings.push_back(r);
   endtask

   // Mostly good readings across the whole range, with a share of faulted
   // ones and of values right at the 10 mV margin.
   task automatic queue_random(int count);
      int ref_mv;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0, 1: queue_reading($urandom_range(4095), $urandom_range(4095));
            2: begin
               ref_mv = $urandom_range(4095, 10);
               queue_reading(ref_mv, ref_mv - 10 + $urandom_range(1));
            end
            default: begin
               ref_mv = $urandom_range(4095, 11);
               queue_reading(ref_mv, $urandom_range(ref_mv - 11));
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      wait (pending_readings.size() == 0 && expected_temps.size() == 0 && !req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register settings per phase: pull-up, nominal, beta, reference temp.
   // They cover the range ends, a zero pull-up with zero beta, a zero nominal
   // resistance, a setting that drives the sum negative, and the defaults.
   logic [19:0] set_pullup[8]  = '{20'd10000, 20'd1, 20'd1000000, 20'hFFFFF,
                                   20'd0, 20'd10000, 20'd1, 20'd10000};
   logic [19:0] set_nominal[8] = '{20'd10000, 20'd1000000, 20'd1, 20'hFFFFF,
                                   20'd10000, 20'd0, 20'hFFFFF, 20'd10000};
   logic [19:0] set_beta[8]    = '{20'd3950, 20'd1000, 20'd10000, 20'd16383,
                                   20'd0, 20'd3950, 20'd1, 20'd3950};
   logic [19:0] set_t0[8]      = '{20'd25, 20'd0, 20'd100, 20'd127,
                                   20'd25, 20'd50, 20'd25, 20'd25};

   initial begin
      pullup_ohms = 20'd10000;
      nominal_ohms = 20'd10000;
      beta_kelvin = 14'd3950;
      nominal_temp_c = 7'd25;
      in_fault = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      running <= 1'b1;

      for (int phase = 0; phase < 8; phase++) begin
         // Idling: receiver-heavy first, then sender-heavy, then none.
         send_idle_pct = (phase < 3) ? 19 : (phase < 6) ? 54 : 0;
         recv_idle_pct = (phase < 3) ? 54 : (phase < 6) ? 19 : 0;
         if (phase > 0) begin
            write_register(CSR_PULLUP, set_pullup[phase]);
            write_register(CSR_NOMINAL, set_nominal[phase]);
            write_register(CSR_BETA, set_beta[phase]);
            write_register(CSR_T0, set_t0[phase]);
         end
         if (phase == 1) begin
            // Writes to unused indexes must change nothing.
            write_register(4'd4, 20'hFFFFF);
            write_register(4'd15, 20'h00000);
         end
         if (phase == 0) begin
            // Directed: faulted start, margin edges, range ends, fault entry.
            queue_reading(0, 0);
            queue_reading(4095, 4095);
            queue_reading(9, 0);
            queue_reading(10, 0);
            queue_reading(11, 0);
            queue_reading(12, 1);
            queue_reading(3300, 1650);
            queue_reading(3300, 3290);
            queue_reading(3300, 3289);
            queue_reading(4095, 4084);
            queue_reading(0, 4095);
            queue_reading(4095, 0);
            queue_reading(4095, 1);
            queue_reading(4095, 4000);
            queue_reading(3300, 100);
            queue_reading(3300, 3000);
            queue_reading(2048, 2048);
            queue_reading(2048, 2047);
            queue_reading(2730, 1365);
            queue_reading(4095, 2730);
         end
         if (phase == 1)
            hold_requests = hold_requests + 1;
         queue_random(220);
         wait_idle();
      end

      $display("Covered %0d good readings (%0d saturated) and %0d faulted readings",
               n_ok, n_clamped, n_fault);
      $display("with %0d fault entries across 8 register settings.", n_raised);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
